// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, quiet while reset is held
`define SIRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked property that also holds across reset
`define SIRS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/sirs_pkg.sv =====
// types, constants and helpers for the subordinate id range start block
`timescale 1ns / 1ps

package sirs_pkg;

  localparam int ID_W      = 32;
  localparam int STAT_W    = 3;
  localparam int PROD_W    = 2 * ID_W;
  localparam int CFG_IDX_W = 3;
  // one remainder step per dividend bit
  localparam int DIV_STEPS = PROD_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UID_BASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWEST_ID   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGHEST_ID  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_ENABLE = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BELOW     = 3'd1;
  localparam logic [STAT_W-1:0] ST_ZERO_CNT  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd4;
  localparam logic [STAT_W-1:0] ST_BEYOND    = 3'd5;

  localparam logic [ID_W-1:0] ERR_START = '1;

  // reset values of the registers
  localparam logic [ID_W-1:0] RST_UID_BASE    = 32'd0;
  localparam logic [ID_W-1:0] RST_LOWEST_ID   = 32'd0;
  localparam logic [ID_W-1:0] RST_HIGHEST_ID  = 32'hFFFF_FFFE;
  localparam logic [ID_W-1:0] RST_BLOCK_COUNT = 32'h0001_0000;

  typedef struct packed {
    logic [ID_W-1:0] uid_base;
    logic [ID_W-1:0] lowest_id;
    logic [ID_W-1:0] highest_id;
    logic [ID_W-1:0] block_count;
    logic            wrap_enable;
  } cfg_t;

  // item as it moves along the remainder chain
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   start;
    logic [PROD_W-1:0] dvd;
    logic [ID_W-1:0]   rem;
  } item_t;

  // size of the id space, wraps to zero for the full 32-bit range
  function automatic logic [ID_W-1:0] space_of(cfg_t c);
    return c.highest_id - c.lowest_id + ID_W'(1);
  endfunction

endpackage

// ===== rtl/sirs_front.sv =====
// front stages: offset, product and the strict range checks
`timescale 1ns / 1ps

module sirs_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sirs_pkg::cfg_t       cfg,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic [sirs_pkg::ID_W-1:0] up_user_id,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output sirs_pkg::item_t      dn_item
);

  logic [sirs_pkg::ID_W-1:0] space;

  logic v0_r, v1_r, v2_r, v3_r;
  logic r0, r1, r2, r3;

  // stage 0 payload
  logic [sirs_pkg::ID_W-1:0]   offset0_r;
  logic                        below0_r;
  logic [sirs_pkg::ID_W:0]     diff0_nxt;

  // stage 1 payload
  logic [sirs_pkg::PROD_W-1:0] prod1_r, prod1_nxt;
  logic [sirs_pkg::STAT_W-1:0] st1_r, st1_nxt;

  // stage 2 payload
  logic [sirs_pkg::PROD_W-1:0] prod2_r;
  logic [sirs_pkg::STAT_W-1:0] st2_r;
  logic [sirs_pkg::ID_W:0]     start2_r, start2_nxt;
  logic                        hi2_r;

  // stage 3 payload
  sirs_pkg::item_t             item3_r, item3_nxt;
  logic [sirs_pkg::ID_W+1:0]   end3;

  assign space = sirs_pkg::space_of(cfg);

  // ready ripples back through empty stages
  assign r3 = !v3_r || dn_ready;
  assign r2 = !v2_r || r3;
  assign r1 = !v1_r || r2;
  assign r0 = !v0_r || r1;
  assign up_ready = r0;

  // offset with borrow as the below-base flag
  assign diff0_nxt = {1'b0, up_user_id} - {1'b0, cfg.uid_base};

  // early checks and the product
  always_comb begin
    prod1_nxt = sirs_pkg::PROD_W'(offset0_r) * sirs_pkg::PROD_W'(cfg.block_count);
    if (below0_r) begin
      st1_nxt = sirs_pkg::ST_BELOW;
    end else if (cfg.block_count == '0) begin
      st1_nxt = sirs_pkg::ST_ZERO_CNT;
    end else if (cfg.block_count > space) begin
      st1_nxt = sirs_pkg::ST_NO_SPACE;
    end else begin
      st1_nxt = sirs_pkg::ST_OK;
    end
  end

  // start of the block in strict mode
  assign start2_nxt = {1'b0, cfg.lowest_id} + {1'b0, prod1_r[sirs_pkg::ID_W-1:0]};

  // end of the block and the strict verdict
  assign end3 = {1'b0, start2_r} + {2'b00, cfg.block_count - sirs_pkg::ID_W'(1)};

  always_comb begin
    item3_nxt.start = start2_r[sirs_pkg::ID_W-1:0];
    item3_nxt.dvd   = prod2_r;
    item3_nxt.rem   = '0;
    if (st2_r != sirs_pkg::ST_OK) begin
      item3_nxt.status = st2_r;
    end else if (cfg.wrap_enable) begin
      item3_nxt.status = sirs_pkg::ST_OK;
    end else if (hi2_r || start2_r[sirs_pkg::ID_W] ||
                 (end3[sirs_pkg::ID_W+1:sirs_pkg::ID_W] != 2'b00)) begin
      item3_nxt.status = sirs_pkg::ST_OVERFLOW;
    end else if (end3[sirs_pkg::ID_W-1:0] > cfg.highest_id) begin
      item3_nxt.status = sirs_pkg::ST_BEYOND;
    end else begin
      item3_nxt.status = sirs_pkg::ST_OK;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (r0) v0_r <= up_valid;
      if (r1) v1_r <= v0_r;
      if (r2) v2_r <= v1_r;
      if (r3) v3_r <= v2_r;
    end
  end

  // payload moves with its stage
  always_ff @(posedge clk) begin
    if (r0) begin
      offset0_r <= diff0_nxt[sirs_pkg::ID_W-1:0];
      below0_r  <= diff0_nxt[sirs_pkg::ID_W];
    end
    if (r1) begin
      prod1_r <= prod1_nxt;
      st1_r   <= st1_nxt;
    end
    if (r2) begin
      prod2_r  <= prod1_r;
      st2_r    <= st1_r;
      start2_r <= start2_nxt;
      hi2_r    <= |prod1_r[sirs_pkg::PROD_W-1:sirs_pkg::ID_W];
    end
    if (r3) begin
      item3_r <= item3_nxt;
    end
  end

  assign dn_valid = v3_r;
  assign dn_item  = item3_r;

endmodule

// ===== rtl/sirs_div_cell.sv =====
// one restoring remainder step per cell, one dividend bit each
`timescale 1ns / 1ps

module sirs_div_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [sirs_pkg::ID_W-1:0] space,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  sirs_pkg::item_t           up_item,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output sirs_pkg::item_t           dn_item
);

  logic            valid_r;
  sirs_pkg::item_t item_r, item_nxt;
  logic [sirs_pkg::ID_W:0] trial;
  logic [sirs_pkg::ID_W:0] diff;

  assign up_ready = !valid_r || dn_ready;

  // shift in the next dividend bit, subtract the space where it fits
  assign trial = {up_item.rem, up_item.dvd[sirs_pkg::PROD_W-1]};
  assign diff  = trial - {1'b0, space};

  always_comb begin
    item_nxt        = up_item;
    item_nxt.dvd    = {up_item.dvd[sirs_pkg::PROD_W-2:0], 1'b0};
    if (trial >= {1'b0, space}) begin
      item_nxt.rem = diff[sirs_pkg::ID_W-1:0];
    end else begin
      item_nxt.rem = trial[sirs_pkg::ID_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

// ===== rtl/subordinate_id_range_start.sv =====
// top level: registers, front stages, remainder chain and output register
//
//  channel | direction | ports                                   | accepted when
//  in      | input     | in_valid, in_stall, in_user_id          | in_valid && !in_stall
//  out     | output    | out_valid, out_stall, out_range_start,  | out_valid && !out_stall
//          |           | out_status                              |
//  cfg     | input     | cfg_we, cfg_index, cfg_data             | cfg_we
//
// one item per cycle while out_stall is low; an item passes four front stages, 64 remainder
//   cells (one dividend bit each, 64-bit product by 32-bit space) and the output register
// throughput comes from cells each holding one item, passing it on every unstalled cycle
// reset clears the valid flags of every stage and the registers to their defaults
// a stall on the output backs the chain up stage by stage; in_stall rises only once
//   every stage holds an item

`timescale 1ns / 1ps
`include "assert_macros.svh"

module subordinate_id_range_start (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [sirs_pkg::ID_W-1:0]      in_user_id,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sirs_pkg::ID_W-1:0]      out_range_start,
  output logic [sirs_pkg::STAT_W-1:0]    out_status,
  input  logic                           cfg_we,
  input  logic [sirs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sirs_pkg::ID_W-1:0]      cfg_data
);

  sirs_pkg::cfg_t cfg_r;
  logic [sirs_pkg::ID_W-1:0] space;

  logic            front_ready;
  logic            chain_valid [sirs_pkg::DIV_STEPS+1];
  logic            chain_ready [sirs_pkg::DIV_STEPS+1];
  sirs_pkg::item_t chain_item  [sirs_pkg::DIV_STEPS+1];

  logic                        out_valid_r;
  logic [sirs_pkg::ID_W-1:0]   range_start_r, range_start_nxt;
  logic [sirs_pkg::STAT_W-1:0] status_r;
  logic                        out_ready;
  sirs_pkg::item_t             last_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.uid_base    <= sirs_pkg::RST_UID_BASE;
      cfg_r.lowest_id   <= sirs_pkg::RST_LOWEST_ID;
      cfg_r.highest_id  <= sirs_pkg::RST_HIGHEST_ID;
      cfg_r.block_count <= sirs_pkg::RST_BLOCK_COUNT;
      cfg_r.wrap_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sirs_pkg::REG_UID_BASE:    cfg_r.uid_base    <= cfg_data;
        sirs_pkg::REG_LOWEST_ID:   cfg_r.lowest_id   <= cfg_data;
        sirs_pkg::REG_HIGHEST_ID:  cfg_r.highest_id  <= cfg_data;
        sirs_pkg::REG_BLOCK_COUNT: cfg_r.block_count <= cfg_data;
        sirs_pkg::REG_WRAP_ENABLE: cfg_r.wrap_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign space = sirs_pkg::space_of(cfg_r);

  // front stages
  sirs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .up_valid   (in_valid),
    .up_ready   (front_ready),
    .up_user_id (in_user_id),
    .dn_valid   (chain_valid[0]),
    .dn_ready   (chain_ready[0]),
    .dn_item    (chain_item[0])
  );

  assign in_stall = !front_ready;

  // remainder chain
  for (genvar i = 0; i < sirs_pkg::DIV_STEPS; i++) begin : g_cell
    sirs_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .space    (space),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_item  (chain_item[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_item  (chain_item[i+1])
    );
  end

  // output register
  assign out_ready = !out_valid_r || !out_stall;
  assign chain_ready[sirs_pkg::DIV_STEPS] = out_ready;
  assign last_item = chain_item[sirs_pkg::DIV_STEPS];

  always_comb begin
    if (last_item.status != sirs_pkg::ST_OK) begin
      range_start_nxt = sirs_pkg::ERR_START;
    end else if (cfg_r.wrap_enable) begin
      range_start_nxt = cfg_r.lowest_id + last_item.rem;
    end else begin
      range_start_nxt = last_item.start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= chain_valid[sirs_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      range_start_r <= range_start_nxt;
      status_r      <= last_item.status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_range_start = range_start_r;
  assign out_status      = status_r;

  // checks
  `SIRS_ASSERT(a_err_start,
    (out_valid_r && (status_r != sirs_pkg::ST_OK)) |->
      (range_start_r == sirs_pkg::ERR_START),
    "error result without the error start")
  `SIRS_ASSERT(a_stall_full,
    in_stall |-> (out_valid_r && out_stall && chain_valid[0]),
    "input stalled with room in the pipeline")
  `SIRS_ASSERT(a_chain_hold,
    (chain_valid[sirs_pkg::DIV_STEPS] && !out_ready) |=>
      (chain_valid[sirs_pkg::DIV_STEPS] && $stable(last_item)),
    "last cell lost its item under stall")
  `SIRS_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid_r, "output valid right after reset")

endmodule

// ===== bench/sirs_range_checker.sv =====
// checker for the range start block: mirrors the registers, predicts and compares
`timescale 1ns / 1ps

module sirs_range_checker
  import sirs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [ID_W-1:0]      in_user_id,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [ID_W-1:0]      out_range_start,
  input  logic [STAT_W-1:0]    out_status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ID_W-1:0]      cfg_data,
  output int                   error_count,
  output int                   outstanding
);

  typedef struct packed {
    logic [ID_W-1:0]   start;
    logic [STAT_W-1:0] status;
  } lookup_t;

  cfg_t    settings;
  lookup_t starts_due_q[$];
  int      errs = 0;

  // first id of the user's block and the status, under the given settings
  function automatic lookup_t range_start_of(cfg_t c, logic [ID_W-1:0] uid);
    logic [ID_W-1:0]   offset;
    logic [ID_W-1:0]   span;
    logic [ID_W-1:0]   tail;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] first;
    logic [PROD_W-1:0] last;
    lookup_t           r;
    r.start = ERR_START;
    offset  = uid - c.uid_base;
    span    = c.highest_id - c.lowest_id + 32'd1;
    tail    = c.block_count - 32'd1;
    prod    = PROD_W'(offset) * PROD_W'(c.block_count);
    first   = PROD_W'(c.lowest_id) + prod;
    last    = first + PROD_W'(tail);
    if (uid < c.uid_base) begin
      r.status = ST_BELOW;
    end else if (c.block_count == '0) begin
      r.status = ST_ZERO_CNT;
    end else if (c.block_count > span) begin
      // a full 32-bit space wraps to zero and lands here too
      r.status = ST_NO_SPACE;
    end else if (c.wrap_enable) begin
      r.status = ST_OK;
      r.start  = c.lowest_id + ID_W'(prod % PROD_W'(span));
    end else if (prod[PROD_W-1:ID_W] != '0 || first[PROD_W-1:ID_W] != '0 ||
                 last[PROD_W-1:ID_W] != '0) begin
      r.status = ST_OVERFLOW;
    end else if (last[ID_W-1:0] > c.highest_id) begin
      r.status = ST_BEYOND;
    end else begin
      r.status = ST_OK;
      r.start  = first[ID_W-1:0];
    end
    return r;
  endfunction

  // watch all three ports at each edge
  always @(posedge clk) begin : watch
    lookup_t want;
    if (!rst_n) begin
      settings = '{uid_base: RST_UID_BASE, lowest_id: RST_LOWEST_ID,
                   highest_id: RST_HIGHEST_ID, block_count: RST_BLOCK_COUNT,
                   wrap_enable: 1'b0};
      starts_due_q.delete();
    end else begin
      // delivered item against the oldest prediction
      if (out_valid && !out_stall) begin
        if (starts_due_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected item, expected none, got start %h status %0d",
                   $time, out_range_start, out_status);
        end else begin
          want = starts_due_q.pop_front();
          if (out_range_start !== want.start) begin
            errs++;
            $display("%0t: range_start mismatch, expected %h, got %h",
                     $time, want.start, out_range_start);
          end
          if (out_status !== want.status) begin
            errs++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_status);
          end
        end
      end
      // accepted user id
      if (in_valid && !in_stall)
        starts_due_q.push_back(range_start_of(settings, in_user_id));
      // register writes, unknown indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          REG_UID_BASE:    settings.uid_base    = cfg_data;
          REG_LOWEST_ID:   settings.lowest_id   = cfg_data;
          REG_HIGHEST_ID:  settings.highest_id  = cfg_data;
          REG_BLOCK_COUNT: settings.block_count = cfg_data;
          REG_WRAP_ENABLE: settings.wrap_enable = cfg_data[0];
          default: ;
        endcase
      end
    end
    error_count <= errs;
    outstanding <= starts_due_q.size();
  end

endmodule

// ===== bench/tb_subordinate_id_range_start.sv =====
// testbench top: clock, reset, stimulus and verdict for the range start block
`timescale 1ns / 1ps

module tb_subordinate_id_range_start;
  import sirs_pkg::*;

  localparam int PIPE_LAT     = 69;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1650;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [ID_W-1:0]      in_user_id;
  logic                 out_valid;
  logic                 out_stall;
  logic [ID_W-1:0]      out_range_start;
  logic [STAT_W-1:0]    out_status;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ID_W-1:0]      cfg_data;
  int                   fail_count;
  int                   pending;

  // settings last written, used to aim the random user ids
  logic [ID_W-1:0] set_base;
  logic [ID_W-1:0] set_low;
  logic [ID_W-1:0] set_high;
  logic [ID_W-1:0] set_count;

  subordinate_id_range_start dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_user_id(in_user_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_range_start(out_range_start), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sirs_range_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_user_id(in_user_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_range_start(out_range_start), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .error_count(fail_count), .outstanding(pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // overall time limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("subordinate_id_range_start verification failed");
    $finish;
  end

  // receiver stall pattern: quiet, light, heavy and alternating stretches
  initial begin : stall_gen
    int mode;
    int span;
    int k;
    out_stall <= 1'b0;
    forever begin
      mode = $urandom_range(3, 0);
      span = $urandom_range(200, 20);
      for (k = 0; k < span; k++) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(3, 0) == 0);
          2: out_stall <= ($urandom_range(3, 0) != 0);
          default: out_stall <= k[0];
        endcase
      end
    end
  end

  // one register write per cycle, the enable stays up for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // hold off until every predicted item has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write a full set of registers while the block is idle
  task automatic load_settings(input logic [ID_W-1:0] base, input logic [ID_W-1:0] low,
                               input logic [ID_W-1:0] high, input logic [ID_W-1:0] count,
                               input logic wrap);
    drain();
    write_reg(REG_UID_BASE, base);
    write_reg(REG_LOWEST_ID, low);
    write_reg(REG_HIGHEST_ID, high);
    write_reg(REG_BLOCK_COUNT, count);
    // upper bits of the wrap write carry noise
    write_reg(REG_WRAP_ENABLE, (ID_W'($urandom()) & ~ID_W'(1)) | ID_W'(wrap));
    if ($urandom_range(3, 0) == 0) write_reg(REG_SPARE, $urandom());
    cfg_we    <= 1'b0;
    set_base  = base;
    set_low   = low;
    set_high  = high;
    set_count = count;
  endtask

  // present one user id and hold it until taken
  task automatic send_uid(input logic [ID_W-1:0] uid);
    in_valid   <= 1'b1;
    in_user_id <= uid;
    do @(posedge clk); while (in_stall);
  endtask

  // mostly ids inside or just past the configured range, some below it, some anywhere
  function automatic logic [ID_W-1:0] pick_uid();
    logic [ID_W-1:0] room;
    logic [63:0]     span;
    logic [63:0]     reach;
    int unsigned     roll;
    roll  = $urandom_range(99, 0);
    room  = set_high - set_low + 32'd1;
    span  = (room == '0) ? 64'h1_0000_0000 : 64'(room);
    reach = (set_count == '0) ? 64'd16 : span / 64'(set_count) + 64'd2;
    if (reach > 64'(32'hFFFF_FFFF - set_base)) reach = 64'(32'hFFFF_FFFF - set_base);
    if (roll < 12 && set_base != '0) return $urandom_range(set_base - 32'd1, 0);
    if (roll < 28) return $urandom();
    return set_base + $urandom_range(reach[31:0], 0);
  endfunction

  // one of the corner values of a 32-bit register, or now and then a random value
  function automatic logic [ID_W-1:0] pick_extreme();
    case ($urandom_range(6, 0))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'hFFFF_FFFE;
      5: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // new random settings, mostly well-formed strict or ring spaces
  task automatic random_settings();
    logic [ID_W-1:0] low;
    logic [ID_W-1:0] count;
    logic [63:0]     top;
    int unsigned     roll;
    roll = $urandom_range(9, 0);
    if (roll < 4) begin
      // strict space sized for a few thousand users
      low   = $urandom_range(32'h7FFF_FFFF, 0);
      count = $urandom_range(32'd1 << $urandom_range(20, 0), 1);
      top   = 64'(low) + 64'(count) * 64'($urandom_range(3000, 1)) +
              64'($urandom_range(count, 0)) - 64'd1;
      load_settings($urandom_range(32'd1 << $urandom_range(31, 0), 0), low,
                    (top > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : top[31:0], count, 1'b0);
    end else if (roll < 7) begin
      // ring space, either order of the bounds
      load_settings($urandom_range(32'd1 << $urandom_range(31, 0), 0), $urandom(),
                    $urandom(), $urandom_range(32'd1 << $urandom_range(16, 0), 1), 1'b1);
    end else if (roll < 8) begin
      load_settings($urandom(), $urandom(), $urandom(), $urandom(),
                    1'($urandom_range(1, 0)));
    end else begin
      load_settings(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                    1'($urandom_range(1, 0)));
    end
  endtask

  // stimulus and verdict
  initial begin : stimulus
    int sent;
    int phase_len;
    int burst_left;
    int gap;
    int k;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_user_id <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    set_base   = RST_UID_BASE;
    set_low    = RST_LOWEST_ID;
    set_high   = RST_HIGHEST_ID;
    set_count  = RST_BLOCK_COUNT;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: in range, end past highest, product overflow
    send_uid(32'h0000_0000);
    send_uid(32'h0000_0001);
    send_uid(32'h0000_FFFE);
    send_uid(32'h0000_FFFF);
    send_uid(32'h0001_0000);
    send_uid(32'hFFFF_FFFF);
    // small strict space: below base, first and last block, one past the end, the highest id
    load_settings(32'd10, 32'h0000_1000, 32'h0000_1FFF, 32'h0000_0100, 1'b0);
    send_uid(32'd9);
    send_uid(32'd10);
    send_uid(32'd25);
    send_uid(32'd26);
    send_uid(32'hFFFF_FFFF);
    // zero block count
    load_settings(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0);
    send_uid(32'd0);
    send_uid(32'd5);
    // full 32-bit space with the highest base
    load_settings(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1, 1'b1);
    send_uid(32'hFFFF_FFFE);
    send_uid(32'hFFFF_FFFF);
    // strict space at the top: fits, end overflows, start overflows
    load_settings(32'd0, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h0000_0060, 1'b0);
    send_uid(32'd1);
    send_uid(32'd2);
    send_uid(32'd3);
    // ring with highest below lowest
    load_settings(32'd0, 32'hFFFF_FFF0, 32'h0000_000F, 32'd3, 1'b1);
    send_uid(32'd5);
    send_uid(32'd6);
    send_uid(32'hFFFF_FFFF);
    // ring with the largest block count
    load_settings(32'd0, 32'd0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1);
    send_uid(32'd2);
    send_uid(32'hFFFF_FFFF);

    // random phases, bursts of items with random gaps
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      random_settings();
      phase_len  = $urandom_range(200, 60);
      burst_left = $urandom_range(32, 1);
      for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        send_uid(pick_uid());
        sent++;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(32, 1);
          gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
          if ($urandom_range(15, 0) == 0) gap = $urandom_range(40, 10);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end

    drain();
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("subordinate_id_range_start verification clean");
    end else begin
      $display("subordinate_id_range_start verification failed");
    end
    $finish;
  end

endmodule
